/* rtl/bbtc_pkg.sv */
// Shared types and constants of the beam bunch time classifier.
package bbtc_pkg;

    // Operation codes of an input word.
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD_RANGE = 2'd0;
    localparam t_op OP_LOAD_TIME  = 2'd1;
    localparam t_op OP_CLASSIFY   = 2'd2;

    // Configuration register indexes.
    typedef logic [1:0] t_cfg_index;
    localparam t_cfg_index CFG_BUNCH_COUNT  = 2'd0;
    localparam t_cfg_index CFG_MATCH_WINDOW = 2'd1;
    localparam t_cfg_index CFG_COSMIC_EN    = 2'd2;

    localparam int CFG_DATA_W = 31;
    localparam logic [3:0] BUNCH_COUNT_RESET = 4'd8;

    // Only eight slots can be addressed by a load word.
    localparam int SLOT_LIMIT = 8;

    localparam logic signed [3:0] INDEX_NONE = -4'sd1;
    localparam logic signed [3:0] INDEX_COSMIC = 4'sd0;

    typedef struct packed {
        t_op                op;
        logic [3:0]         row;
        logic [2:0]         bunch_slot;
        logic [19:0]        range_first;
        logic [19:0]        range_last;
        logic signed [31:0] slot_time;
        logic               is_mc;
        logic signed [31:0] track_time;
        logic [19:0]        run;
    } t_item;

    typedef struct packed {
        logic [3:0]  bunch_count;
        logic [30:0] match_window;
        logic        cosmic_en;
    } t_cfg;

    // Control that travels with a classify word through the slot scan.
    typedef struct packed {
        logic valid;
        logic none;
    } t_cls_ctl;

endpackage

/* rtl/bbtc_range_match.sv */
// Run range table with parallel range compare and lowest-row priority encode.
module bbtc_range_match #(
    parameter int NUM_PERIODS = 16,
    localparam int ADDR_W = $clog2(NUM_PERIODS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bbtc_pkg::t_item     i_item,
    output logic                o_valid,
    output bbtc_pkg::t_item     o_item,
    output logic                o_found,
    output logic [ADDR_W-1:0]   o_row
);

    logic [19:0]            r_low  [NUM_PERIODS];
    logic [19:0]            r_high [NUM_PERIODS];
    logic [NUM_PERIODS-1:0] r_tab_valid;
    logic [NUM_PERIODS-1:0] r_hit;
    logic [NUM_PERIODS-1:0] n_hit;
    logic                   r_valid;
    bbtc_pkg::t_item        r_item;
    logic                   load;

    assign load = i_valid && (i_item.op == bbtc_pkg::OP_LOAD_RANGE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tab_valid <= '0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= i_valid;
            for (int p = 0; p < NUM_PERIODS; p++) begin
                if (load && (32'(i_item.row) == p)) begin
                    r_tab_valid[p] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PERIODS; p++) begin
            if (load && (32'(i_item.row) == p)) begin
                r_low[p]  <= i_item.range_first;
                r_high[p] <= i_item.range_last;
            end
        end
        r_hit  <= n_hit;
        r_item <= i_item;
    end

    // A range whose first run exceeds its last run never hits.
    always_comb begin
        for (int p = 0; p < NUM_PERIODS; p++) begin
            n_hit[p] = r_tab_valid[p] && (i_item.run >= r_low[p])
                       && (i_item.run <= r_high[p]);
        end
    end

    always_comb begin
        o_row = '0;
        for (int p = NUM_PERIODS - 1; p >= 0; p--) begin
            if (r_hit[p]) begin
                o_row = ADDR_W'(p);
            end
        end
    end

    assign o_found = |r_hit;
    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/bbtc_bunch_store.sv */
// Bunch time store: one memory per slot lane, rows for periods plus simulation.
module bbtc_bunch_store #(
    parameter int NUM_PERIODS = 16,
    parameter int MAX_BUNCHES = 8,
    localparam int ADDR_W = $clog2(NUM_PERIODS + 1),
    localparam int LANES = (MAX_BUNCHES < bbtc_pkg::SLOT_LIMIT) ? MAX_BUNCHES
                                                              : bbtc_pkg::SLOT_LIMIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  bbtc_pkg::t_item     i_item,
    input  logic                i_found,
    input  logic [ADDR_W-1:0]   i_row,
    output bbtc_pkg::t_cls_ctl  o_ctl,
    output logic signed [31:0]  o_track,
    output logic [31:0]         o_times [LANES]
);

    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    bbtc_pkg::t_cls_ctl r_ctl;
    logic signed [31:0] r_track;

    // A data row equal to the period count lands in the simulation row.
    assign we = i_valid && (i_item.op == bbtc_pkg::OP_LOAD_TIME)
                && (i_item.is_mc || (32'(i_item.row) <= NUM_PERIODS));
    assign waddr = i_item.is_mc ? ADDR_W'(NUM_PERIODS) : ADDR_W'(i_item.row);
    assign raddr = i_item.is_mc ? ADDR_W'(NUM_PERIODS) : i_row;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic [31:0] mem [NUM_PERIODS + 1];
        logic [31:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (we && (i_item.bunch_slot == 3'(l))) begin
                mem[waddr] <= i_item.slot_time;
            end
            r_rd <= mem[raddr];
        end

        assign o_times[l] = r_rd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl.valid <= i_valid && (i_item.op == bbtc_pkg::OP_CLASSIFY);
        end
        r_ctl.none <= !i_item.is_mc && !i_found;
        r_track    <= i_item.track_time;
    end

    assign o_ctl   = r_ctl;
    assign o_track = r_track;

endmodule

/* rtl/bbtc_slot_scan.sv */
// Slot scan: per-lane time difference, window compare, first-slot select.
module bbtc_slot_scan #(
    parameter int MAX_BUNCHES = 8,
    localparam int LANES = (MAX_BUNCHES < bbtc_pkg::SLOT_LIMIT) ? MAX_BUNCHES
                                                              : bbtc_pkg::SLOT_LIMIT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bbtc_pkg::t_cfg      i_cfg,
    input  bbtc_pkg::t_cls_ctl  i_ctl,
    input  logic signed [31:0]  i_track,
    input  logic [31:0]         i_times [LANES],
    output logic                o_valid,
    output logic signed [3:0]   o_bunch_index
);

    bbtc_pkg::t_cls_ctl r_ctl3;
    bbtc_pkg::t_cls_ctl r_ctl4;
    logic [31:0]        r_mag [LANES];
    logic [LANES-1:0]   r_tneg;
    logic [LANES-1:0]   r_stop;
    logic [LANES-1:0]   r_stop_neg;
    logic [LANES-1:0]   n_stop;
    logic [LANES-1:0]   n_stop_neg;
    logic [2:0]         pick;
    logic               pick_neg;
    logic               any_stop;
    logic signed [3:0]  n_index;
    logic               r_valid;
    logic signed [3:0]  r_index;

    // Both differences are formed at once; the non-negative one is the magnitude.
    for (genvar l = 0; l < LANES; l++) begin : g_diff
        logic signed [32:0] d_fwd;
        logic signed [32:0] d_rev;
        logic [32:0]        n_mag;

        assign d_fwd = {i_track[31], i_track} - {i_times[l][31], i_times[l]};
        assign d_rev = {i_times[l][31], i_times[l]} - {i_track[31], i_track};
        assign n_mag = d_fwd[32] ? d_rev : d_fwd;

        always_ff @(posedge i_clk) begin
            r_mag[l]  <= n_mag[31:0];
            r_tneg[l] <= i_times[l][31];
        end
    end

    // A lane stops the scan on a negative stored time or on a window match.
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_stop[l] = (4'(l) < i_cfg.bunch_count)
                        && (r_tneg[l] || ({1'b0, r_mag[l]} < {2'b00, i_cfg.match_window}));
            n_stop_neg[l] = r_tneg[l];
        end
    end

    always_comb begin
        pick     = '0;
        pick_neg = 1'b0;
        for (int l = LANES - 1; l >= 0; l--) begin
            if (r_stop[l]) begin
                pick     = 3'(l);
                pick_neg = r_stop_neg[l];
            end
        end
        any_stop = |r_stop;
        if (i_cfg.cosmic_en) begin
            n_index = bbtc_pkg::INDEX_COSMIC;
        end else if (r_ctl4.none || !any_stop || pick_neg) begin
            n_index = bbtc_pkg::INDEX_NONE;
        end else begin
            n_index = $signed({1'b0, pick});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3.valid <= 1'b0;
            r_ctl4.valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_ctl3.valid <= i_ctl.valid;
            r_ctl4.valid <= r_ctl3.valid;
            r_valid      <= r_ctl4.valid;
        end
        r_ctl3.none <= i_ctl.none;
        r_ctl4.none <= r_ctl3.none;
        r_stop      <= n_stop;
        r_stop_neg  <= n_stop_neg;
        r_index     <= n_index;
    end

    assign o_valid       = r_valid;
    assign o_bunch_index = r_index;

endmodule

/* rtl/beam_bunch_time_classifier.sv */
// Top level of the beam bunch time classifier: input capture, configuration, pipeline.
// A word is taken at every cycle; busy stays low and the pipeline never holds.
// A classify result appears on o_bunch_index with o_valid after the input register and the
// registered stages of range compare, store read, difference, window and select.
// Loads give no result; they update the tables in pipeline order behind earlier words.
// Synchronous reset clears the pipeline and range valid bits and presets the configuration.
module beam_bunch_time_classifier #(
    parameter int NUM_PERIODS = 16,
    parameter int MAX_BUNCHES = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [3:0]          i_row,
    input  logic [2:0]          i_bunch_slot,
    input  logic [19:0]         i_range_first,
    input  logic [19:0]         i_range_last,
    input  logic signed [31:0]  i_slot_time,
    input  logic                i_is_mc,
    input  logic signed [31:0]  i_track_time,
    input  logic [19:0]         i_run,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [bbtc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                o_valid,
    output logic signed [3:0]   o_bunch_index
);

    localparam int ADDR_W = $clog2(NUM_PERIODS + 1);
    localparam int LANES = (MAX_BUNCHES < bbtc_pkg::SLOT_LIMIT) ? MAX_BUNCHES
                                                              : bbtc_pkg::SLOT_LIMIT;

    bbtc_pkg::t_cfg     r_cfg;
    logic               r_s1_valid;
    bbtc_pkg::t_item    r_s1_item;
    logic               s2_valid;
    bbtc_pkg::t_item    s2_item;
    logic               s2_found;
    logic [ADDR_W-1:0]  s2_row;
    bbtc_pkg::t_cls_ctl s3_ctl;
    logic signed [31:0] s3_track;
    logic [31:0]        s3_times [LANES];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bunch_count  <= bbtc_pkg::BUNCH_COUNT_RESET;
            r_cfg.match_window <= '0;
            r_cfg.cosmic_en    <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bbtc_pkg::CFG_BUNCH_COUNT: begin
                    r_cfg.bunch_count <= i_cfg_data[3:0];
                end
                bbtc_pkg::CFG_MATCH_WINDOW: begin
                    r_cfg.match_window <= i_cfg_data[30:0];
                end
                bbtc_pkg::CFG_COSMIC_EN: begin
                    r_cfg.cosmic_en <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= start && !busy;
        end
        r_s1_item.op          <= i_operation;
        r_s1_item.row         <= i_row;
        r_s1_item.bunch_slot  <= i_bunch_slot;
        r_s1_item.range_first <= i_range_first;
        r_s1_item.range_last  <= i_range_last;
        r_s1_item.slot_time   <= i_slot_time;
        r_s1_item.is_mc       <= i_is_mc;
        r_s1_item.track_time  <= i_track_time;
        r_s1_item.run         <= i_run;
    end

    bbtc_range_match #(
        .NUM_PERIODS (NUM_PERIODS)
    ) u_range (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_s1_valid),
        .i_item  (r_s1_item),
        .o_valid (s2_valid),
        .o_item  (s2_item),
        .o_found (s2_found),
        .o_row   (s2_row)
    );

    bbtc_bunch_store #(
        .NUM_PERIODS (NUM_PERIODS),
        .MAX_BUNCHES (MAX_BUNCHES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .i_item  (s2_item),
        .i_found (s2_found),
        .i_row   (s2_row),
        .o_ctl   (s3_ctl),
        .o_track (s3_track),
        .o_times (s3_times)
    );

    bbtc_slot_scan #(
        .MAX_BUNCHES (MAX_BUNCHES)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_ctl         (s3_ctl),
        .i_track       (s3_track),
        .i_times       (s3_times),
        .o_valid       (o_valid),
        .o_bunch_index (o_bunch_index)
    );

`ifndef NO_ASSERTIONS
    // Every accepted classify word is followed by a result on o_valid.
    a_classify_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation == bbtc_pkg::OP_CLASSIFY)) |-> ##6 o_valid)
        else $error("classify word produced no result");

    // Load and unused words never produce a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_operation != bbtc_pkg::OP_CLASSIFY)) |-> ##6 !o_valid)
        else $error("non-classify word produced a result");

    // A result is either no match or a slot that the scan can reach.
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_bunch_index == bbtc_pkg::INDEX_NONE)
                     || (32'($unsigned(o_bunch_index)) < LANES)))
        else $error("bunch index out of range");

    // Cosmic mode forces bunch zero.
    a_cosmic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_cfg.cosmic_en) |-> (o_bunch_index == bbtc_pkg::INDEX_COSMIC))
        else $error("cosmic mode result is not bunch zero");
`endif

endmodule

/* test/tb_beam_bunch_time_classifier.sv */
// Self-checking testbench for the beam bunch time classifier.
`timescale 1ns / 1ps

module tb_beam_bunch_time_classifier;

    localparam int N_PERIODS = 16;
    localparam int N_SLOTS = 8;
    localparam int LIMIT = 200000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES = 7;
    localparam int PHASE_WORDS = 52;
    localparam int TIME_SPAN = 60000;
    localparam int SPREAD = 3000;
    localparam int RANGE_SPAN = 4000;
    localparam int RUN_TOP = 1048575;
    // A directed classify whose answer is left to the predictor.
    localparam int CALC = 100;
    localparam bbtc_pkg::t_op OP_UNUSED = 2'd3;
    localparam bbtc_pkg::t_cfg_index CFG_UNUSED_INDEX = 2'd3;

    typedef struct {
        logic                           is_cfg;
        bbtc_pkg::t_cfg_index           idx;
        logic [bbtc_pkg::CFG_DATA_W-1:0] val;
        bbtc_pkg::t_item                w;
        logic                           typed;
        logic signed [3:0]              want;
    } t_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_operation;
    logic [3:0]             i_row;
    logic [2:0]             i_bunch_slot;
    logic [19:0]            i_range_first;
    logic [19:0]            i_range_last;
    logic signed [31:0]     i_slot_time;
    logic                   i_is_mc;
    logic signed [31:0]     i_track_time;
    logic [19:0]            i_run;
    logic                   i_cfg_we;
    logic [1:0]             i_cfg_index;
    logic [bbtc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                   o_valid;
    logic signed [3:0]      o_bunch_index;

    // Mirror of the block's tables and registers.
    logic [19:0]            rng_lo [N_PERIODS];
    logic [19:0]            rng_hi [N_PERIODS];
    logic                   rng_ok [N_PERIODS];
    logic signed [31:0]     slot_tm [N_PERIODS + 1][N_SLOTS];
    logic [3:0]             slots_cfg;
    logic [30:0]            window_cfg;
    logic                   cosmic_on;

    logic signed [3:0]      pending_idx [$];
    logic signed [3:0]      oldest;
    int                     errors = 0;
    int unsigned            cycles = 0;
    logic                   idle_on = 1'b1;

    beam_bunch_time_classifier #(
        .NUM_PERIODS(N_PERIODS),
        .MAX_BUNCHES(N_SLOTS)
    ) i_dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_operation(i_operation),
        .i_row(i_row),
        .i_bunch_slot(i_bunch_slot),
        .i_range_first(i_range_first),
        .i_range_last(i_range_last),
        .i_slot_time(i_slot_time),
        .i_is_mc(i_is_mc),
        .i_track_time(i_track_time),
        .i_run(i_run),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .o_bunch_index(o_bunch_index)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_idx.size() == 0) begin
                $display("%0t: unexpected bunch index, expected none, actual %0d",
                         $time, o_bunch_index);
                errors++;
            end else begin
                oldest = pending_idx.pop_front();
                if (o_bunch_index !== oldest) begin
                    $display("%0t: bunch index mismatch, expected %0d, actual %0d",
                             $time, oldest, o_bunch_index);
                    errors++;
                end
            end
        end
    end

    function automatic logic signed [3:0] pick_bunch(logic signed [31:0] track,
                                                    logic [19:0] run, logic mc);
        int sel;
        int scan;
        longint diff;
        if (cosmic_on)
            return bbtc_pkg::INDEX_COSMIC;
        sel = N_PERIODS;
        if (!mc) begin
            sel = -1;
            for (int i = N_PERIODS - 1; i >= 0; i--) begin
                if (rng_ok[i] && run >= rng_lo[i] && run <= rng_hi[i])
                    sel = i;
            end
            if (sel < 0)
                return bbtc_pkg::INDEX_NONE;
        end
        scan = (int'(slots_cfg) > N_SLOTS) ? N_SLOTS : int'(slots_cfg);
        if (scan > bbtc_pkg::SLOT_LIMIT)
            scan = bbtc_pkg::SLOT_LIMIT;
        for (int j = 0; j < scan; j++) begin
            // A negative stored time marks the end of the usable slots.
            if (slot_tm[sel][j] < 0)
                return bbtc_pkg::INDEX_NONE;
            diff = longint'(track) - longint'(slot_tm[sel][j]);
            if (diff < 0)
                diff = -diff;
            if (diff < longint'(window_cfg))
                return 4'(j);
        end
        return bbtc_pkg::INDEX_NONE;
    endfunction

    function automatic void book_word(bbtc_pkg::t_item w, logic typed,
                                      logic signed [3:0] want);
        case (w.op)
            bbtc_pkg::OP_LOAD_RANGE: begin
                rng_lo[w.row] = w.range_first;
                rng_hi[w.row] = w.range_last;
                rng_ok[w.row] = 1'b1;
            end
            bbtc_pkg::OP_LOAD_TIME: begin
                slot_tm[w.is_mc ? N_PERIODS : int'(w.row)][w.bunch_slot] = w.slot_time;
            end
            bbtc_pkg::OP_CLASSIFY: begin
                pending_idx.insert(pending_idx.size(),
                                   typed ? want : pick_bunch(w.track_time, w.run, w.is_mc));
            end
            default: ;
        endcase
    endfunction

    function automatic bbtc_pkg::t_item junk_word();
        logic [159:0] bits;
        bits = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
        return bits[$bits(bbtc_pkg::t_item)-1:0];
    endfunction

    function automatic logic signed [31:0] rand_time();
        int unsigned k;
        k = $urandom_range(0, 15);
        if (k == 0)
            return {1'b1, 31'($urandom())};
        if (k == 1)
            return $urandom();
        return $urandom_range(0, TIME_SPAN);
    endfunction

    function automatic bbtc_pkg::t_item rand_word();
        bbtc_pkg::t_item w;
        int unsigned pick;
        int k;
        int other;
        int src;
        int off;
        w = junk_word();
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
            w.op = bbtc_pkg::OP_LOAD_RANGE;
            other = $urandom_range(0, N_PERIODS - 1);
            k = $urandom_range(0, 9);
            if (k >= 2 && k < 5 && rng_ok[other]) begin
                // Overlap another period so that the lowest matching row must win.
                w.range_first = rng_lo[other] - 20'($urandom_range(0, 50));
                w.range_last = rng_hi[other] + 20'($urandom_range(0, 50));
            end else if (k >= 2) begin
                w.range_first = 20'($urandom_range(0, RUN_TOP - RANGE_SPAN));
                w.range_last = w.range_first + 20'($urandom_range(0, RANGE_SPAN));
            end
        end else if (pick < 24) begin
            w.op = bbtc_pkg::OP_LOAD_TIME;
            w.is_mc = ($urandom_range(0, 3) == 0);
            w.slot_time = rand_time();
        end else if (pick < 96) begin
            w.op = bbtc_pkg::OP_CLASSIFY;
            w.is_mc = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, N_PERIODS - 1);
            if (rng_ok[k] && rng_lo[k] <= rng_hi[k] && $urandom_range(0, 7) != 0)
                w.run = 20'($urandom_range(rng_hi[k], rng_lo[k]));
            src = w.is_mc ? N_PERIODS : k;
            if ($urandom_range(0, 6) != 0) begin
                off = $urandom_range(0, 2 * SPREAD);
                off = off - SPREAD;
                w.track_time = slot_tm[src][$urandom_range(0, N_SLOTS - 1)] + 32'(off);
            end
        end else begin
            w.op = OP_UNUSED;
        end
        return w;
    endfunction

    function automatic t_row mk_word(bbtc_pkg::t_item w, int want);
        t_row r;
        r.is_cfg = 1'b0;
        r.idx = bbtc_pkg::CFG_BUNCH_COUNT;
        r.val = '0;
        r.w = w;
        r.typed = (want != CALC);
        r.want = 4'(want);
        return r;
    endfunction

    function automatic t_row mk_cfg(bbtc_pkg::t_cfg_index idx,
                                    logic [bbtc_pkg::CFG_DATA_W-1:0] val);
        t_row r;
        r = mk_word(junk_word(), CALC);
        r.is_cfg = 1'b1;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic t_row mk_range(logic [3:0] row, logic [19:0] first,
                                      logic [19:0] last, logic mc);
        bbtc_pkg::t_item w;
        w = junk_word();
        w.op = bbtc_pkg::OP_LOAD_RANGE;
        w.row = row;
        w.range_first = first;
        w.range_last = last;
        w.is_mc = mc;
        return mk_word(w, CALC);
    endfunction

    function automatic t_row mk_time(logic [3:0] row, logic [2:0] slot,
                                     logic signed [31:0] tm, logic mc);
        bbtc_pkg::t_item w;
        w = junk_word();
        w.op = bbtc_pkg::OP_LOAD_TIME;
        w.row = row;
        w.bunch_slot = slot;
        w.slot_time = tm;
        w.is_mc = mc;
        return mk_word(w, CALC);
    endfunction

    function automatic t_row mk_classify(logic signed [31:0] track, logic [19:0] run,
                                         logic mc, int want);
        bbtc_pkg::t_item w;
        w = junk_word();
        w.op = bbtc_pkg::OP_CLASSIFY;
        w.track_time = track;
        w.run = run;
        w.is_mc = mc;
        return mk_word(w, want);
    endfunction

    // Offers one word and returns at the edge that takes it.
    task automatic drive_word(bbtc_pkg::t_item w, logic typed, logic signed [3:0] want);
        int gap;
        if ($urandom_range(0, 23) == 0)
            idle_on = !idle_on;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_operation <= w.op;
        i_row <= w.row;
        i_bunch_slot <= w.bunch_slot;
        i_range_first <= w.range_first;
        i_range_last <= w.range_last;
        i_slot_time <= w.slot_time;
        i_is_mc <= w.is_mc;
        i_track_time <= w.track_time;
        i_run <= w.run;
        do @(posedge i_clk); while (busy);
        book_word(w, typed, want);
    endtask

    // Drains every pending result and lets trailing loads leave the pipeline.
    task automatic settle();
        start <= 1'b0;
        while (pending_idx.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(bbtc_pkg::t_cfg_index idx,
                             logic [bbtc_pkg::CFG_DATA_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        case (idx)
            bbtc_pkg::CFG_BUNCH_COUNT:  slots_cfg = val[3:0];
            bbtc_pkg::CFG_MATCH_WINDOW: window_cfg = val;
            bbtc_pkg::CFG_COSMIC_EN:    cosmic_on = val[0];
            default: ;
        endcase
    endtask

    initial begin
        t_row tbl [$];
        bbtc_pkg::t_item w;
        logic [3:0] bc;
        logic [30:0] win;
        logic cos;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_operation = bbtc_pkg::OP_LOAD_RANGE;
        i_row = '0;
        i_bunch_slot = '0;
        i_range_first = '0;
        i_range_last = '0;
        i_slot_time = '0;
        i_is_mc = 1'b0;
        i_track_time = '0;
        i_run = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = bbtc_pkg::CFG_BUNCH_COUNT;
        i_cfg_data = '0;
        for (int i = 0; i < N_PERIODS; i++) begin
            rng_lo[i] = '0;
            rng_hi[i] = '0;
            rng_ok[i] = 1'b0;
        end
        for (int i = 0; i <= N_PERIODS; i++)
            for (int j = 0; j < N_SLOTS; j++)
                slot_tm[i][j] = '0;
        slots_cfg = bbtc_pkg::BUNCH_COUNT_RESET;
        window_cfg = '0;
        cosmic_on = 1'b0;

        // A classify before any range has been loaded finds no period and gives no match.
        tbl.insert(tbl.size(), mk_classify(32'sd0, 20'd0, 1'b0, bbtc_pkg::INDEX_NONE));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_COSMIC_EN, 31'd1));
        tbl.insert(tbl.size(), mk_classify(32'sh8000_0000, 20'hFFFFF, 1'b1,
                                           bbtc_pkg::INDEX_COSMIC));
        tbl.insert(tbl.size(), mk_classify(32'sh7FFF_FFFF, 20'd0, 1'b0,
                                           bbtc_pkg::INDEX_COSMIC));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_COSMIC_EN, 31'd0));
        tbl.insert(tbl.size(), mk_time(4'($urandom()), 3'd0, 32'sd0, 1'b1));
        tbl.insert(tbl.size(), mk_time(4'($urandom()), 3'd1, 32'sd1000, 1'b1));
        tbl.insert(tbl.size(), mk_time(4'($urandom()), 3'd2, 32'sh7FFF_FFFF, 1'b1));
        tbl.insert(tbl.size(), mk_time(4'($urandom()), 3'd3, -32'sd1, 1'b1));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_BUNCH_COUNT, 31'd4));
        tbl.insert(tbl.size(), mk_classify(32'sd0, 20'($urandom()), 1'b1,
                                           bbtc_pkg::INDEX_NONE));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_MATCH_WINDOW, 31'h7FFF_FFFF));
        tbl.insert(tbl.size(), mk_classify(32'sh7FFF_FFFF, 20'($urandom()), 1'b1, CALC));
        tbl.insert(tbl.size(), mk_classify(32'sh8000_0000, 20'($urandom()), 1'b1, CALC));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_MATCH_WINDOW, 31'd1));
        tbl.insert(tbl.size(), mk_classify(32'sd1000, 20'($urandom()), 1'b1, CALC));
        tbl.insert(tbl.size(), mk_classify(32'sd999, 20'($urandom()), 1'b1, CALC));
        tbl.insert(tbl.size(), mk_range(4'd15, 20'hFFFFF, 20'hFFFFF, 1'b1));
        tbl.insert(tbl.size(), mk_range(4'd0, 20'd10, 20'd5, 1'b0));
        tbl.insert(tbl.size(), mk_time(4'd15, 3'd0, 32'sh7FFF_FFFF, 1'b0));
        tbl.insert(tbl.size(), mk_time(4'd15, 3'd7, 32'sh8000_0000, 1'b0));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_BUNCH_COUNT, 31'd1));
        tbl.insert(tbl.size(), mk_classify(32'sh7FFF_FFFF, 20'hFFFFF, 1'b0, CALC));
        tbl.insert(tbl.size(), mk_classify(32'sd0, 20'd7, 1'b0, bbtc_pkg::INDEX_NONE));
        w = junk_word();
        w.op = OP_UNUSED;
        tbl.insert(tbl.size(), mk_word(w, CALC));
        tbl.insert(tbl.size(), mk_cfg(bbtc_pkg::CFG_BUNCH_COUNT, 31'd0));
        tbl.insert(tbl.size(), mk_classify(32'sd1000, 20'($urandom()), 1'b1,
                                           bbtc_pkg::INDEX_NONE));
        tbl.insert(tbl.size(), mk_cfg(CFG_UNUSED_INDEX, 31'h7FFF_FFFF));
        tbl.insert(tbl.size(), mk_classify(32'sd1000, 20'($urandom()), 1'b1,
                                           bbtc_pkg::INDEX_NONE));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (tbl[i]) begin
            if (tbl[i].is_cfg) begin
                settle();
                write_reg(tbl[i].idx, tbl[i].val);
                i_cfg_we <= 1'b0;
            end else begin
                drive_word(tbl[i].w, tbl[i].typed, tbl[i].want);
            end
        end

        // Fill every bunch time and every period range before random traffic.
        for (int r = 0; r <= N_PERIODS; r++) begin
            for (int s = 0; s < N_SLOTS; s++) begin
                w = junk_word();
                w.op = bbtc_pkg::OP_LOAD_TIME;
                w.is_mc = (r == N_PERIODS);
                if (r < N_PERIODS)
                    w.row = 4'(r);
                w.bunch_slot = 3'(s);
                w.slot_time = rand_time();
                drive_word(w, 1'b0, '0);
            end
        end
        for (int r = 0; r < N_PERIODS; r++) begin
            w = junk_word();
            w.op = bbtc_pkg::OP_LOAD_RANGE;
            w.row = 4'(r);
            w.range_first = 20'($urandom_range(0, RUN_TOP - RANGE_SPAN));
            w.range_last = w.range_first + 20'($urandom_range(0, RANGE_SPAN));
            drive_word(w, 1'b0, '0);
        end

        for (int p = 0; p < PHASES; p++) begin
            cos = 1'b0;
            win = 31'($urandom_range(1, SPREAD));
            case (p)
                0: begin
                    bc = 4'd15;
                    win = 31'h7FFF_FFFF;
                end
                1: bc = 4'd8;
                2: bc = 4'd1;
                3: bc = 4'd0;
                4: begin
                    bc = 4'($urandom());
                    cos = 1'b1;
                end
                default: begin
                    bc = 4'($urandom());
                    if ($urandom_range(0, 1) == 0)
                        win = 31'($urandom());
                end
            endcase
            settle();
            // Upper data bits of the narrow registers carry noise.
            write_reg(bbtc_pkg::CFG_BUNCH_COUNT, {27'($urandom()), bc});
            write_reg(bbtc_pkg::CFG_MATCH_WINDOW, win);
            write_reg(bbtc_pkg::CFG_COSMIC_EN, {30'($urandom()), cos});
            if ($urandom_range(0, 1) == 0)
                write_reg(CFG_UNUSED_INDEX, 31'($urandom()));
            i_cfg_we <= 1'b0;
            for (int n = 0; n < PHASE_WORDS; n++)
                drive_word(rand_word(), 1'b0, '0);
        end

        settle();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/bbtc_pkg.sv
rtl/bbtc_range_match.sv
rtl/bbtc_bunch_store.sv
rtl/bbtc_slot_scan.sv
rtl/beam_bunch_time_classifier.sv
test/tb_beam_bunch_time_classifier.sv
